FILE: rtl/csma_pkg.sv
// shared types, widths and register codes for the clamp/scale moving average unit
// no dependencies; the rtl files refer to it by scoped names, the testbench imports it
package csma_pkg;

  localparam int DATA_W     = 16;
  localparam int FRAC_W     = 12;
  localparam int REG_IDX_W  = 8;
  localparam int WINDOW_DEF = 8;
  localparam int PROD_W     = 2 * DATA_W + 1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [REG_IDX_W-1:0]     reg_idx_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IN_LOW  = 8'd0,
    REG_IN_HIGH = 8'd1,
    REG_OUT_LOW = 8'd2,
    REG_GAIN    = 8'd3
  } reg_code_t;

  typedef struct packed {
    data_t in_low;
    data_t in_high;
    data_t out_low;
    data_t gain;
  } cfg_t;

  localparam data_t IN_LOW_RST  = 16'sh8000;
  localparam data_t IN_HIGH_RST = 16'sh7fff;
  localparam data_t OUT_LOW_RST = 16'sh0000;
  localparam data_t GAIN_RST    = 16'sh1000;

endpackage

FILE: rtl/csma_sample_if.sv
// sample channel: valid/ready handshake carrying one raw sensor word
// depends on csma_pkg
interface csma_sample_if;
  logic            valid;
  logic            ready;
  csma_pkg::data_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/csma_avg_if.sv
// result channel: valid/ready handshake carrying one averaged word
// depends on csma_pkg
interface csma_avg_if;
  logic            valid;
  logic            ready;
  csma_pkg::data_t average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

FILE: rtl/csma_cfg_if.sv
// configuration write channel: valid/ready with register index and write data
// depends on csma_pkg
interface csma_cfg_if;
  logic               valid;
  logic               ready;
  csma_pkg::reg_idx_t index;
  csma_pkg::data_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/csma_map.sv
// input register, clamp and gain multiply, then floor shift, offset and saturation
// depends on csma_pkg
module csma_map (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  csma_pkg::data_t  sample,
  input  csma_pkg::cfg_t   cfg_regs,
  output logic             map_valid,
  output csma_pkg::data_t  mapped
);

  logic                                 s0_valid;
  csma_pkg::data_t                      s0_sample;
  logic                                 s1_valid;
  logic signed [csma_pkg::PROD_W-1:0]   prod;

  csma_pkg::data_t                      clamped;
  logic signed [csma_pkg::DATA_W:0]     diff;
  logic signed [csma_pkg::PROD_W-1:0]   prod_next;
  logic signed [csma_pkg::PROD_W-csma_pkg::FRAC_W-1:0] scaled;
  logic signed [csma_pkg::PROD_W-csma_pkg::FRAC_W:0]   offs;
  csma_pkg::data_t                      mapped_next;

  // clamp, low bound checked first
  always_comb begin
    if (s0_sample < cfg_regs.in_low) begin
      clamped = cfg_regs.in_low;
    end else if (s0_sample > cfg_regs.in_high) begin
      clamped = cfg_regs.in_high;
    end else begin
      clamped = s0_sample;
    end
    diff      = {clamped[csma_pkg::DATA_W-1], clamped}
              - {cfg_regs.in_low[csma_pkg::DATA_W-1], cfg_regs.in_low};
    prod_next = (csma_pkg::PROD_W)'(diff) * (csma_pkg::PROD_W)'(cfg_regs.gain);
  end

  // floor shift, add offset, saturate to word range
  always_comb begin
    scaled = prod[csma_pkg::PROD_W-1:csma_pkg::FRAC_W];
    offs   = {scaled[csma_pkg::PROD_W-csma_pkg::FRAC_W-1], scaled}
           + (csma_pkg::PROD_W-csma_pkg::FRAC_W+1)'(cfg_regs.out_low);
    if (offs > (csma_pkg::PROD_W-csma_pkg::FRAC_W+1)'(32'sd32767)) begin
      mapped_next = 16'sh7fff;
    end else if (offs < (csma_pkg::PROD_W-csma_pkg::FRAC_W+1)'(-32'sd32768)) begin
      mapped_next = 16'sh8000;
    end else begin
      mapped_next = offs[csma_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      map_valid <= 1'b0;
    end else if (en) begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      map_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sample <= sample;
      prod      <= prod_next;
      mapped    <= mapped_next;
    end
  end

endmodule

FILE: rtl/csma_window.sv
// circular window memory with read-ahead port and running sum
// depends on csma_pkg
module csma_window #(
  parameter int WINDOW = csma_pkg::WINDOW_DEF,
  parameter int PW     = $clog2(WINDOW),
  parameter int SW     = csma_pkg::DATA_W + PW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 map_valid,
  input  csma_pkg::data_t      mapped,
  output logic                 sum_valid,
  output logic signed [SW-1:0] sum
);

  localparam logic [PW-1:0] LAST = PW'(WINDOW - 1);

  csma_pkg::data_t  mem [WINDOW];
  csma_pkg::data_t  rd;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    pos_next;
  logic [PW-1:0]    rd_addr;
  logic             full;
  logic             wr;
  csma_pkg::data_t  old;
  logic signed [SW-1:0] sum_next;

  // entries are written in order, so the entry about to be overwritten holds data only after the first lap
  always_comb begin
    wr       = en && map_valid;
    pos_next = (pos == LAST) ? '0 : pos + PW'(1);
    rd_addr  = wr ? pos_next : pos;
    old      = full ? rd : '0;
    sum_next = sum + SW'(mapped) - SW'(old);
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[pos] <= mapped;
    end
    rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      full      <= 1'b0;
      sum       <= '0;
      sum_valid <= 1'b0;
    end else begin
      if (en) begin
        sum_valid <= map_valid;
      end
      if (wr) begin
        pos <= pos_next;
        sum <= sum_next;
        if (pos == LAST) begin
          full <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/csma_divide.sv
// divide window sum by WINDOW, truncating toward zero, via reciprocal multiply
// depends on csma_pkg
module csma_divide #(
  parameter int WINDOW = csma_pkg::WINDOW_DEF,
  parameter int PW     = $clog2(WINDOW),
  parameter int SW     = csma_pkg::DATA_W + PW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 sum_valid,
  input  logic signed [SW-1:0] sum,
  output logic                 avg_valid,
  output csma_pkg::data_t      average
);

  localparam int SH = SW + PW;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [SW:0] RECIP = RECIP_FULL[SW:0];

  logic              s4_valid;
  logic              s4_neg;
  logic [SW-1:0]     mag;
  logic              s5_valid;
  logic              s5_neg;
  logic [2*SW:0]     prod;

  logic [SW-1:0]                  mag_next;
  logic [csma_pkg::DATA_W:0]      quot;
  logic [csma_pkg::DATA_W:0]      quot_signed;

  always_comb begin
    mag_next    = sum[SW-1] ? SW'(-sum) : SW'(sum);
    quot        = prod[SH +: csma_pkg::DATA_W + 1];
    quot_signed = s5_neg ? ((csma_pkg::DATA_W + 1)'(0) - quot) : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      avg_valid <= 1'b0;
    end else if (en) begin
      s4_valid  <= sum_valid;
      s5_valid  <= s4_valid;
      avg_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_neg  <= sum[SW-1];
      mag     <= mag_next;
      s5_neg  <= s4_neg;
      prod    <= (2*SW+1)'(mag) * (2*SW+1)'(RECIP);
      average <= quot_signed[csma_pkg::DATA_W-1:0];
    end
  end

endmodule

FILE: rtl/clamp_scale_moving_average_unit.sv
// clamp, linear map and boxcar average of a signed sample stream
// stage registers: sample, product, mapped word, sum, magnitude, quotient product, result
// throughput: one sample per cycle; the pipeline advances whenever the result register is free
// reset: config registers to defaults, window empty (reads as zeros), all stages invalid
// depends on csma_pkg, csma_sample_if, csma_avg_if, csma_cfg_if and the csma_* stages
module clamp_scale_moving_average_unit #(
  parameter int WINDOW = csma_pkg::WINDOW_DEF
) (
  input  logic    clk,
  input  logic    rst,
  csma_cfg_if.sink      cfg,
  csma_sample_if.sink   samples,
  csma_avg_if.source    averages
);

  localparam int PW = $clog2(WINDOW);
  localparam int SW = csma_pkg::DATA_W + PW;

  csma_pkg::cfg_t        cfg_regs;
  logic                  en;
  logic                  map_valid;
  csma_pkg::data_t       mapped;
  logic                  sum_valid;
  logic signed [SW-1:0]  sum;

  assign en            = !averages.valid || averages.ready;
  assign samples.ready = en;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.in_low  <= csma_pkg::IN_LOW_RST;
      cfg_regs.in_high <= csma_pkg::IN_HIGH_RST;
      cfg_regs.out_low <= csma_pkg::OUT_LOW_RST;
      cfg_regs.gain    <= csma_pkg::GAIN_RST;
    end else if (cfg.valid) begin
      case (csma_pkg::reg_code_t'(cfg.index))
        csma_pkg::REG_IN_LOW:  cfg_regs.in_low  <= cfg.data;
        csma_pkg::REG_IN_HIGH: cfg_regs.in_high <= cfg.data;
        csma_pkg::REG_OUT_LOW: cfg_regs.out_low <= cfg.data;
        csma_pkg::REG_GAIN:    cfg_regs.gain    <= cfg.data;
        default: ;
      endcase
    end
  end

  csma_map u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (samples.valid),
    .sample    (samples.sample),
    .cfg_regs  (cfg_regs),
    .map_valid (map_valid),
    .mapped    (mapped)
  );

  csma_window #(
    .WINDOW (WINDOW),
    .PW     (PW),
    .SW     (SW)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .map_valid (map_valid),
    .mapped    (mapped),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  csma_divide #(
    .WINDOW (WINDOW),
    .PW     (PW),
    .SW     (SW)
  ) u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .sum_valid (sum_valid),
    .sum       (sum),
    .avg_valid (averages.valid),
    .average   (averages.average)
  );

endmodule

FILE: rtl/csma_checker.sv
// port-level checks for the clamp/scale moving average unit, bound to the top level
// depends on csma_pkg and clamp_scale_moving_average_unit
module csma_checker (
  input logic            clk,
  input logic            rst,
  input logic            cfg_ready,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input csma_pkg::data_t average
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // input side stalls only behind a held result word
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output backpressure");

  // a stalled result word holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(average))
    else $error("stalled result word changed");

  // no input word is accepted during a stall
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("word accepted while result stalled");

  // config writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

endmodule

bind clamp_scale_moving_average_unit csma_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg.ready),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (averages.valid),
  .out_ready (averages.ready),
  .average   (averages.average)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// testbench for clamp_scale_moving_average_unit: directed and random samples, config changes
// depends on csma_pkg, the csma_sample_if, csma_avg_if and csma_cfg_if interfaces and clamp_scale_moving_average_unit
import csma_pkg::*;

class boxcar_predictor;
  localparam int SUM_W = DATA_W + $clog2(WINDOW_DEF);

  data_t in_low, in_high, out_low, gain;
  data_t taps [WINDOW_DEF];
  int unsigned slot;
  logic signed [SUM_W-1:0] window_sum;
  data_t pending_averages [$];
  int mismatches;

  function new();
    in_low = IN_LOW_RST;
    in_high = IN_HIGH_RST;
    out_low = OUT_LOW_RST;
    gain = GAIN_RST;
    foreach (taps[i]) taps[i] = '0;
    slot = 0;
    window_sum = '0;
    mismatches = 0;
  endfunction

  function void write_reg(reg_idx_t idx, data_t value);
    case (idx)
      REG_IN_LOW:  in_low = value;
      REG_IN_HIGH: in_high = value;
      REG_OUT_LOW: out_low = value;
      REG_GAIN:    gain = value;
      default: ;
    endcase
  endfunction

  function data_t map_sample(data_t s);
    data_t clamped;
    logic signed [DATA_W:0] span;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-FRAC_W:0] level;
    clamped = s;
    if (s < in_low) begin
      clamped = in_low;
    end else if (s > in_high) begin
      clamped = in_high;
    end
    span = clamped - in_low;
    prod = span * gain;
    // arithmetic shift floors toward minus infinity
    level = (prod >>> FRAC_W) + out_low;
    if (level < -32768) return 16'sh8000;
    if (level > 32767) return 16'sh7fff;
    return data_t'(level);
  endfunction

  function void note_sample(data_t s);
    data_t mapped;
    mapped = map_sample(s);
    window_sum = window_sum + mapped - taps[slot];
    taps[slot] = mapped;
    slot = (slot + 1) % WINDOW_DEF;
    // signed division truncates toward zero
    pending_averages.push_back(data_t'(window_sum / WINDOW_DEF));
  endfunction

  function void check_average(data_t actual);
    data_t want;
    if (pending_averages.size() == 0) begin
      $display("%0t: unexpected average word, expected none, actual %0d", $time, actual);
      mismatches++;
    end else begin
      want = pending_averages.pop_front();
      if (actual !== want) begin
        $display("%0t: average mismatch, expected %0d, actual %0d", $time, want, actual);
        mismatches++;
      end
    end
  endfunction

  function int pending();
    return pending_averages.size();
  endfunction
endclass

module tb_top;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int quiet_cycles = 0;

  boxcar_predictor model;

  csma_cfg_if    cfg_bus ();
  csma_sample_if smp_bus ();
  csma_avg_if    avg_bus ();

  clamp_scale_moving_average_unit #(.WINDOW(WINDOW_DEF)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_bus),
    .samples  (smp_bus),
    .averages (avg_bus)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    avg_bus.ready <= (int'($urandom_range(0, 99)) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && avg_bus.valid && avg_bus.ready) begin
      model.check_average(avg_bus.average);
    end
  end

  always @(posedge clk) begin
    if ((smp_bus.valid && smp_bus.ready) || (avg_bus.valid && avg_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input data_t s);
    while (int'($urandom_range(0, 99)) < src_idle_pct) begin
      smp_bus.valid <= 1'b0;
      @(posedge clk);
    end
    smp_bus.valid  <= 1'b1;
    smp_bus.sample <= s;
    do @(posedge clk); while (!smp_bus.ready);
    model.note_sample(s);
  endtask

  task automatic drain();
    smp_bus.valid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input data_t value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    model.write_reg(idx, value);
  endtask

  // junk write to an unused index goes last and must leave the map unchanged
  task automatic set_config(input data_t lo, input data_t hi, input data_t base,
                            input data_t slope, input reg_idx_t junk_idx);
    cfg_write(REG_IN_LOW, lo);
    cfg_write(REG_IN_HIGH, hi);
    cfg_write(REG_OUT_LOW, base);
    cfg_write(REG_GAIN, slope);
    cfg_write(junk_idx, data_t'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic random_config();
    int lo;
    int hi;
    reg_idx_t junk;
    junk = reg_idx_t'($urandom_range(4, 255));
    if ($urandom_range(0, 3) == 0) begin
      set_config(data_t'($urandom), data_t'($urandom), data_t'($urandom),
                 data_t'($urandom), junk);
    end else begin
      lo = int'($urandom_range(0, 30000)) - 30000;
      hi = lo + int'($urandom_range(1, 30000));
      set_config(data_t'(lo), data_t'(hi), data_t'(int'($urandom_range(0, 40000)) - 20000),
                 data_t'(int'($urandom_range(0, 16384)) - 4096), junk);
    end
  endtask

  function automatic data_t random_sample();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return data_t'(int'(model.in_low) + int'($urandom_range(0, 8)) - 4);
    if (pick == 1) return data_t'(int'(model.in_high) + int'($urandom_range(0, 8)) - 4);
    return data_t'($urandom);
  endfunction

  initial begin
    model = new();
    smp_bus.valid  <= 1'b0;
    smp_bus.sample <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= '0;
    cfg_bus.data   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, window still full of zeros
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    drain();

    // steep gain with high offset saturates upward
    set_config(-16'sd1000, 16'sd1000, 16'sd30000, 16'sh7fff, reg_idx_t'(4));
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sd999);
    send_sample(16'sd0);
    drain();

    // inverted bounds, most negative gain
    set_config(16'sd500, -16'sd500, 16'sd100, 16'sh8000, reg_idx_t'(255));
    send_sample(-16'sd600);
    send_sample(16'sd600);
    send_sample(16'sd0);
    send_sample(16'sd500);
    send_sample(-16'sd500);
    send_sample(16'sd499);
    drain();

    // tiny negative gain floors to -1 and saturates downward
    set_config(16'sh8000, 16'sh7fff, 16'sh8000, -16'sd1, reg_idx_t'(128));
    send_sample(16'sh7fff);
    send_sample(-16'sd32767);
    send_sample(16'sh8000);
    send_sample(16'sd12345);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
        default: begin src_idle_pct = 6; snk_stall_pct = 6; end
      endcase
      random_config();
      for (int i = 0; i < 50; i++) begin
        if (p == 2 && i == 25) drain();
        send_sample(random_sample());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/csma_pkg.sv
rtl/csma_sample_if.sv
rtl/csma_avg_if.sv
rtl/csma_cfg_if.sv
rtl/csma_map.sv
rtl/csma_window.sv
rtl/csma_divide.sv
rtl/clamp_scale_moving_average_unit.sv
rtl/csma_checker.sv
bench/tb_top.sv
